[sv/chacha20_stream_xor_defines.svh]
// Assertion macros for the ChaCha20 stream block.
`ifndef CHACHA20_STREAM_XOR_DEFINES_SVH
`define CHACHA20_STREAM_XOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CC_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CC_ASSERT_IMPL(label, clk, rst, prop, msg)
`define CC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[sv/ccsx_pkg.sv]
// ----------------------------------------------------------------------------
// ccsx_pkg
// Types, constants and the quarter-round function of the ChaCha20 stream block.
// ----------------------------------------------------------------------------
package ccsx_pkg;

   localparam int RoundCount = 20;
   localparam int DoubleRounds = (RoundCount + 1) / 2;
   localparam int DrWidth = $clog2(DoubleRounds + 1);

   localparam logic [2:0] CSR_KEY0  = 3'd0;
   localparam logic [2:0] CSR_KEY1  = 3'd1;
   localparam logic [2:0] CSR_KEY2  = 3'd2;
   localparam logic [2:0] CSR_KEY3  = 3'd3;
   localparam logic [2:0] CSR_NONCE = 3'd4;
   localparam logic [2:0] CSR_MODE  = 3'd5;

   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] TAU1   = 32'h3120646e;
   localparam logic [31:0] TAU2   = 32'h79622d36;
   localparam logic [31:0] CONST0 = 32'h61707865;
   localparam logic [31:0] CONST3 = 32'h6b206574;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COL,
      ST_DIAG,
      ST_FINAL,
      ST_OUT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;      // load the initial state
      logic col;       // column half-round
      logic diag;      // diagonal half-round
      logic finish;    // add input words, store keystream
      logic take;      // register the result item
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic ready;     // a keystream block is held
      logic rounds_done;
   } status_type;

   typedef logic [3:0][31:0] quad_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   function automatic quad_type qround(input quad_type q);
      logic [31:0] a, b, c, d;
      quad_type r;
      a = q[0]; b = q[1]; c = q[2]; d = q[3];
      a = a + b; d = rotl(d ^ a, 16);
      c = c + d; b = rotl(b ^ c, 12);
      a = a + b; d = rotl(d ^ a, 8);
      c = c + d; b = rotl(b ^ c, 7);
      r[0] = a; r[1] = b; r[2] = c; r[3] = d;
      return r;
   endfunction

endpackage

[sv/ccsx_stream_if.sv]
// ----------------------------------------------------------------------------
// ccsx_stream_if
// Valid/ready channel carrying one data word with byte count and last flag.
// ----------------------------------------------------------------------------
interface ccsx_stream_if;
   logic        valid;
   logic        ready;
   logic [63:0] data;
   logic [3:0]  byte_count;
   logic        last;

   modport source (output valid, output data, output byte_count, output last,
                   input ready);
   modport sink (input valid, input data, input byte_count, input last,
                 output ready);
endinterface

[sv/ccsx_ctrl.sv]
// ----------------------------------------------------------------------------
// ccsx_ctrl
// Sequencer: makes a keystream block when needed, then forms each result.
// ----------------------------------------------------------------------------
`include "chacha20_stream_xor_defines.svh"

module ccsx_ctrl
   import ccsx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic       out_busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (status.ready) begin
                  state_in = ST_OUT;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_COL;
               end
            end
         end
         ST_COL: begin
            if (status.rounds_done) begin
               state_in = ST_FINAL;
            end else begin
               cmd.col  = 1'b1;
               state_in = ST_DIAG;
            end
         end
         ST_DIAG: begin
            cmd.diag = 1'b1;
            state_in = ST_COL;
         end
         ST_FINAL: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // The item transfers only once the output register is free.
            if (!out_busy) begin
               in_ready = 1'b1;
               cmd.take = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `CC_ASSERT_IMPL(a_take_ready, clock, reset, cmd.take |-> status.ready,
      "result taken with no keystream block")
   `CC_ASSERT_IMPL(a_finish_after_rounds, clock, reset,
      cmd.finish |-> $past(state_ff == ST_COL), "finish out of sequence")
   `CC_ASSERT_IMPL(a_out_holds_valid, clock, reset,
      (state_ff == ST_OUT) |-> in_valid, "input dropped during processing")

endmodule

[sv/ccsx_datapath.sv]
// ----------------------------------------------------------------------------
// ccsx_datapath
// Key registers, block counter, four quarter-round lanes and keystream store.
// ----------------------------------------------------------------------------
module ccsx_datapath
   import ccsx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [63:0] item_data,
   input  logic [3:0]  item_count,
   input  logic        item_last,
   output logic [63:0] res_data,
   output logic [3:0]  res_count,
   output logic        res_last
);

   logic [63:0] key_ff [4];
   logic [63:0] nonce_ff;
   logic        mode_ff;
   logic [63:0] counter_ff;
   logic        ready_ff;
   logic [2:0]  pos_ff;
   logic [DrWidth-1:0] dr_ff;
   logic [31:0] w_ff [16];
   logic [31:0] init_ff [16];
   logic [63:0] ks_ff [8];

   logic [31:0] init_in [16];
   logic [31:0] w_in [16];
   logic [63:0] hi_a, hi_b;
   logic [3:0]  cnt;
   logic [63:0] mask;
   quad_type    q [4];
   quad_type    r [4];

   always_comb begin
      hi_a = mode_ff ? key_ff[2] : key_ff[0];
      hi_b = mode_ff ? key_ff[3] : key_ff[1];
      init_in[0]  = CONST0;
      init_in[1]  = mode_ff ? SIGMA1 : TAU1;
      init_in[2]  = mode_ff ? SIGMA2 : TAU2;
      init_in[3]  = CONST3;
      init_in[4]  = key_ff[0][31:0];
      init_in[5]  = key_ff[0][63:32];
      init_in[6]  = key_ff[1][31:0];
      init_in[7]  = key_ff[1][63:32];
      init_in[8]  = hi_a[31:0];
      init_in[9]  = hi_a[63:32];
      init_in[10] = hi_b[31:0];
      init_in[11] = hi_b[63:32];
      init_in[12] = counter_ff[31:0];
      init_in[13] = counter_ff[63:32];
      init_in[14] = nonce_ff[31:0];
      init_in[15] = nonce_ff[63:32];
   end

   // Lane i works on column i, or on the diagonal starting at word i.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q[i][0] = w_ff[i];
         q[i][1] = cmd.diag ? w_ff[4 + ((i + 1) % 4)] : w_ff[4 + i];
         q[i][2] = cmd.diag ? w_ff[8 + ((i + 2) % 4)] : w_ff[8 + i];
         q[i][3] = cmd.diag ? w_ff[12 + ((i + 3) % 4)] : w_ff[12 + i];
         r[i] = qround(q[i]);
      end
      for (int j = 0; j < 16; j++) begin
         w_in[j] = w_ff[j];
      end
      for (int i = 0; i < 4; i++) begin
         w_in[i] = r[i][0];
         if (cmd.diag) begin
            w_in[4 + ((i + 1) % 4)]  = r[i][1];
            w_in[8 + ((i + 2) % 4)]  = r[i][2];
            w_in[12 + ((i + 3) % 4)] = r[i][3];
         end else begin
            w_in[4 + i]  = r[i][1];
            w_in[8 + i]  = r[i][2];
            w_in[12 + i] = r[i][3];
         end
      end
   end

   assign status.ready       = ready_ff;
   assign status.rounds_done = (dr_ff == DrWidth'(DoubleRounds));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int j = 0; j < 16; j++) begin
            w_ff[j]    <= init_in[j];
            init_ff[j] <= init_in[j];
         end
      end else if (cmd.col || cmd.diag) begin
         for (int j = 0; j < 16; j++) begin
            w_ff[j] <= w_in[j];
         end
      end
      if (cmd.finish) begin
         for (int k = 0; k < 8; k++) begin
            ks_ff[k] <= {w_ff[2 * k + 1] + init_ff[2 * k + 1],
                         w_ff[2 * k] + init_ff[2 * k]};
         end
      end
      if (csr_write) begin
         case (csr_index)
            CSR_KEY0:  key_ff[0] <= csr_data;
            CSR_KEY1:  key_ff[1] <= csr_data;
            CSR_KEY2:  key_ff[2] <= csr_data;
            CSR_KEY3:  key_ff[3] <= csr_data;
            CSR_NONCE: nonce_ff  <= csr_data;
            default: ;
         endcase
      end
      if (reset) begin
         key_ff[0] <= '0;
         key_ff[1] <= '0;
         key_ff[2] <= '0;
         key_ff[3] <= '0;
         nonce_ff  <= '0;
      end
   end

   always_comb begin
      cnt = item_count;
      if (cnt == 4'd0) cnt = 4'd1;
      if (cnt > 4'd8) cnt = 4'd8;
      mask = '0;
      for (int b = 0; b < 8; b++) begin
         if (4'(b) < cnt) mask[8 * b +: 8] = 8'hff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         res_data  <= (item_data ^ ks_ff[pos_ff]) & mask;
         res_count <= cnt;
         res_last  <= item_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b1;
         counter_ff <= '0;
         ready_ff   <= 1'b0;
         pos_ff     <= '0;
         dr_ff      <= '0;
      end else begin
         if (cmd.load) begin
            dr_ff <= '0;
         end else if (cmd.diag) begin
            dr_ff <= dr_ff + DrWidth'(1);
         end
         if (cmd.finish) begin
            counter_ff <= counter_ff + 64'd1;
            ready_ff   <= 1'b1;
            pos_ff     <= '0;
         end
         if (cmd.take) begin
            pos_ff <= pos_ff + 3'd1;
            if (pos_ff == 3'd7 || item_last) begin
               ready_ff <= 1'b0;
               pos_ff   <= '0;
            end
         end
         if (csr_write && csr_index == CSR_MODE) begin
            mode_ff <= csr_data[0];
         end
         if (csr_write && csr_index == CSR_NONCE) begin
            counter_ff <= '0;
            ready_ff   <= 1'b0;
            pos_ff     <= '0;
         end
      end
   end

endmodule

[sv/chacha20_stream_xor.sv]
// ----------------------------------------------------------------------------
// chacha20_stream_xor
// ChaCha20 (64-bit nonce) stream cipher, one 64-bit data word per item.
// ----------------------------------------------------------------------------
// Usage: data words come in on the req channel (valid/ready) with a byte count
// and a last flag; each leaves on the rsp channel XORed with keystream, bytes
// past the count zeroed. Keys, nonce and key mode must be written through the
// csr port while the block is idle; the block does not enforce this. Writing
// the nonce clears the block counter. An item that finds keystream held goes
// straight to the result step; one that needs a new block first runs 20
// half-rounds on four shared quarter-round lanes and a finalize step.
// Results sit in an output register; while the receiver stalls, the next
// item is computed up to that register and then waits.
// Reset (synchronous, active high) clears the keys and nonce, selects the
// 256-bit key mode and drops any held keystream.
module chacha20_stream_xor
   import ccsx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ccsx_stream_if.sink   req_ch,
   ccsx_stream_if.source rsp_ch,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;
   logic       out_valid_ff;
   logic [63:0] res_data;
   logic [3:0]  res_count;
   logic        res_last;

   ccsx_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .out_busy (out_valid_ff && !rsp_ch.ready),
      .status   (status),
      .cmd      (cmd)
   );

   ccsx_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write_en),
      .csr_index  (csr_index),
      .csr_data   (csr_write_data),
      .cmd        (cmd),
      .status     (status),
      .item_data  (req_ch.data),
      .item_count (req_ch.byte_count),
      .item_last  (req_ch.last),
      .res_data   (res_data),
      .res_count  (res_count),
      .res_last   (res_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.take) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.data       = res_data;
   assign rsp_ch.byte_count = res_count;
   assign rsp_ch.last       = res_last;

endmodule

[verif/chacha20_stream_xor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_xor_tb
// Self-checking bench: random messages are encrypted by the block and by a
// keystream predictor in the bench, and every result transfer is compared.
// ----------------------------------------------------------------------------
module chacha20_stream_xor_tb;
   import ccsx_pkg::*;

   typedef struct {
      logic [63:0] data;
      logic [3:0]  byte_count;
      logic        last;
   } word_item_t;

   localparam int WatchdogLimit = 20000;
   localparam int DrainCycles = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_write_data = '0;

   ccsx_stream_if req_ch ();
   ccsx_stream_if rsp_ch ();

   chacha20_stream_xor dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_en(csr_write_en), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   // Predictor state.
   logic [63:0] key_word [4];
   logic [63:0] nonce_word;
   logic        long_key;
   logic [63:0] counter_word;
   logic [63:0] key_block [8];
   int          word_index;
   logic        block_held;

   word_item_t pending_words[$];
   word_item_t cipher_words[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  sender_hold = 1'b0;
   bit  req_fired = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;

   function automatic logic [31:0] rot_left(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void mix(ref logic [31:0] w[16], input int a, b, c, d);
      w[a] += w[b]; w[d] = rot_left(w[d] ^ w[a], 16);
      w[c] += w[d]; w[b] = rot_left(w[b] ^ w[c], 12);
      w[a] += w[b]; w[d] = rot_left(w[d] ^ w[a], 8);
      w[c] += w[d]; w[b] = rot_left(w[b] ^ w[c], 7);
   endfunction

   function automatic void refill_keystream();
      logic [31:0] init [16];
      logic [31:0] w [16];
      logic [63:0] hi_a, hi_b;
      init[0] = CONST0;
      init[3] = CONST3;
      init[1] = long_key ? SIGMA1 : TAU1;
      init[2] = long_key ? SIGMA2 : TAU2;
      hi_a = long_key ? key_word[2] : key_word[0];
      hi_b = long_key ? key_word[3] : key_word[1];
      {init[5], init[4]} = key_word[0];
      {init[7], init[6]} = key_word[1];
      {init[9], init[8]} = hi_a;
      {init[11], init[10]} = hi_b;
      {init[13], init[12]} = counter_word;
      {init[15], init[14]} = nonce_word;
      w = init;
      for (int r = 20; r > 0; r -= 2) begin
         mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
         mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
         mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
         mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) w[i] += init[i];
      for (int i = 0; i < 8; i++) key_block[i] = {w[2*i+1], w[2*i]};
      counter_word += 64'd1;
      block_held = 1'b1;
      word_index = 0;
   endfunction

   function automatic word_item_t encrypt_word(word_item_t in);
      word_item_t res;
      int n;
      logic [63:0] mask;
      n = (in.byte_count == 0) ? 1 : (in.byte_count > 8) ? 8 : in.byte_count;
      mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      if (!block_held) refill_keystream();
      res.data = (in.data ^ key_block[word_index]) & mask;
      res.byte_count = 4'(n);
      res.last = in.last;
      word_index = (word_index + 1) % 8;
      if (word_index == 0 || in.last) begin
         block_held = 1'b0;
         word_index = 0;
      end
      return res;
   endfunction

   task automatic write_csr(logic [2:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_KEY0, CSR_KEY1, CSR_KEY2, CSR_KEY3: key_word[idx] = value;
         CSR_NONCE: begin
            nonce_word = value;
            counter_word = '0;
            block_held = 1'b0;
            word_index = 0;
         end
         CSR_MODE: long_key = value[0];
         default: ;
      endcase
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic void queue_word(logic [63:0] d, logic [3:0] n, logic l);
      word_item_t it;
      it.data = d; it.byte_count = n; it.last = l;
      pending_words.push_back(it);
   endfunction

   // Full words, then a last word of random size.
   function automatic void queue_message(int words);
      for (int i = 0; i < words - 1; i++) queue_word(rand64(), 4'd8, 1'b0);
      queue_word(rand64(), 4'($urandom_range(1, 8)), 1'b1);
   endfunction

   task automatic drain();
      while (pending_words.size() != 0 || cipher_words.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   // Driver. A word stays on the channel until the edge that transfers it.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_fired) begin
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_ch.valid <= 1'b0;
      end else if (pending_words.size() != 0 && !sender_hold) begin
         req_ch.valid <= 1'b1;
         req_ch.data <= pending_words[0].data;
         req_ch.byte_count <= pending_words[0].byte_count;
         req_ch.last <= pending_words[0].last;
         send_gap <= ($urandom_range(0, 3) == 0) ?
            (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
      end else begin
         req_ch.valid <= 1'b0;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         recv_gap <= ($urandom_range(0, 3) == 0) ?
            (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
      end
   end

   // Monitor: predict on each request transfer, check each result transfer.
   always @(posedge clock) begin
      word_item_t got;
      word_item_t want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_ch.valid && req_ch.ready;
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (req_ch.valid && req_ch.ready) begin
            got.data = req_ch.data;
            got.byte_count = req_ch.byte_count;
            got.last = req_ch.last;
            cipher_words.push_back(encrypt_word(got));
            void'(pending_words.pop_front());
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (cipher_words.size() == 0) begin
               $error("unexpected result transfer data=%h", rsp_ch.data);
               error_count++;
            end else begin
               want = cipher_words.pop_front();
               if (rsp_ch.data !== want.data) begin
                  $error("data_out: expected %h actual %h", want.data, rsp_ch.data);
                  error_count++;
               end
               if (rsp_ch.byte_count !== want.byte_count) begin
                  $error("out_byte_count: expected %0d actual %0d",
                         want.byte_count, rsp_ch.byte_count);
                  error_count++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("out_last: expected %0d actual %0d", want.last, rsp_ch.last);
                  error_count++;
               end
            end
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] edge_vals [4];
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      req_ch.byte_count = 4'd8;
      req_ch.last = 1'b0;
      rsp_ch.ready = 1'b0;
      key_word = '{default: '0};
      nonce_word = '0;
      long_key = 1'b1;
      counter_word = '0;
      block_held = 1'b0;
      word_index = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset key, field extremes, out-of-range counts, short
      // non-last word, and a block boundary.
      queue_word('0, 4'd8, 1'b0);
      queue_word('1, 4'd1, 1'b0);
      queue_word(64'h0123456789abcdef, 4'd0, 1'b0);
      queue_word('1, 4'd15, 1'b0);
      queue_word(64'haaaa5555aaaa5555, 4'd9, 1'b0);
      for (int i = 0; i < 5; i++) queue_word(rand64(), 4'd8, 1'b0);
      queue_word('1, 4'd3, 1'b1);
      queue_word(rand64(), 4'd7, 1'b1);
      drain();

      // Short key mode and extreme key values, then a key change mid-block.
      edge_vals = '{'0, '1, 64'h8000000000000001, rand64()};
      for (int s = 0; s < 4; s++) begin
         for (int k = 0; k < 4; k++) write_csr(3'(k), edge_vals[(s + k) % 4]);
         write_csr(CSR_MODE, 64'(s % 2));
         write_csr(CSR_NONCE, edge_vals[3 - s]);
         queue_message(3 + s);
         drain();
      end
      queue_word(rand64(), 4'd8, 1'b0);
      queue_word(rand64(), 4'd8, 1'b0);
      drain();
      write_csr(CSR_KEY0, rand64());
      queue_message(8);
      drain();

      // Random phases; the sender holds off until the pipe empties once.
      for (int ph = 0; ph < 10; ph++) begin
         for (int k = 0; k < 4; k++) write_csr(3'(k), rand64());
         write_csr(CSR_MODE, 64'($urandom_range(0, 1)));
         write_csr(CSR_NONCE, rand64());
         for (int m = 0; m < 8; m++) begin
            if ($urandom_range(0, 4) == 0) begin
               queue_word(rand64(), 4'($urandom()), 1'($urandom()));
            end else begin
               queue_message($urandom_range(1, 18));
            end
         end
         if (ph == 3) begin
            while (cipher_words.size() == 0) @(negedge clock);
            sender_hold = 1'b1;
            while (cipher_words.size() != 0) @(negedge clock);
            sender_hold = 1'b0;
         end
         drain();
      end

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
